### design/vital_sign_alarm_annunciator_assert.svh
// Assertion macros for the vital sign alarm annunciator.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef VITAL_SIGN_ALARM_ANNUNCIATOR_ASSERT_SVH
`define VITAL_SIGN_ALARM_ANNUNCIATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define VSAA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vsaa assertion failed");
`define VSAA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vsaa assertion failed");
`else
`define VSAA_ASSERT_IMP(lbl, ante, cons)
`define VSAA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/vsaa_pkg.sv
`default_nettype none

package vsaa_pkg;

  localparam int unsigned TS_W    = 32;
  localparam int unsigned IV_W    = 16;
  localparam int unsigned RD_W    = 10;
  localparam int unsigned TEMP_W  = 14;
  localparam int unsigned RESP_W  = 7;
  localparam int unsigned BAND_W  = 14;
  localparam int unsigned TMR_W   = 3;
  localparam int unsigned CNT_W   = $clog2(TS_W);

  localparam logic [IV_W-1:0]   IV_RESET     = 16'd1;
  localparam logic [RD_W-1:0]   BATT_LOW_LIM = 10'd40;
  localparam logic [TMR_W-1:0]  REARM_CNT    = 3'd6;

  localparam logic [BAND_W-1:0] SYS_A_HI  = 14'd156;
  localparam logic [BAND_W-1:0] SYS_A_LO  = 14'd96;
  localparam logic [BAND_W-1:0] SYS_W_HI  = 14'd136;
  localparam logic [BAND_W-1:0] SYS_W_LO  = 14'd114;
  localparam logic [BAND_W-1:0] DIA_W_HI  = 14'd84;
  localparam logic [BAND_W-1:0] DIA_W_LO  = 14'd66;
  localparam logic [BAND_W-1:0] PUL_A_HI  = 14'd115;
  localparam logic [BAND_W-1:0] PUL_A_LO  = 14'd51;
  localparam logic [BAND_W-1:0] PUL_W_HI  = 14'd105;
  localparam logic [BAND_W-1:0] PUL_W_LO  = 14'd57;
  localparam logic [BAND_W-1:0] TMP_A_HI  = 14'd435;
  localparam logic [BAND_W-1:0] TMP_A_LO  = 14'd307;
  localparam logic [BAND_W-1:0] TMP_W_HI  = 14'd397;
  localparam logic [BAND_W-1:0] TMP_W_LO  = 14'd343;
  localparam logic [BAND_W-1:0] RSP_A_HI  = 14'd23;
  localparam logic [BAND_W-1:0] RSP_A_LO  = 14'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_OUT
  } vsaa_state_e;

  typedef struct packed {
    logic eval;
    logic ack_set;
    logic alarm_band;
    logic warn_band;
  } vsaa_ch_ctl_t;

  typedef struct packed {
    logic alarm;
    logic warn;
  } vsaa_ch_st_t;

  function automatic logic out_of_band_f(logic [BAND_W-1:0] v,
                                         logic [BAND_W-1:0] hi,
                                         logic [BAND_W-1:0] lo);
    return (v > hi) || (v < lo);
  endfunction

endpackage

`default_nettype wire

### design/vsaa_mod.sv
`default_nettype none

// bit-serial restoring remainder, one dividend bit per cycle
module vsaa_mod import vsaa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [TS_W-1:0] dividend_i,
  input  logic [IV_W-1:0] divisor_i,
  output logic            done_o,
  output logic            zero_o
);

  logic [TS_W-1:0]  num_q, num_d;
  logic [IV_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [IV_W:0]    shifted;
  logic [IV_W:0]    diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, num_q[TS_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[TS_W-2:0], 1'b0};
      rem_d = ge ? diff[IV_W-1:0] : shifted[IV_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(TS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

`default_nettype wire

### design/vsaa_chan.sv
`default_nettype none

// one alarm channel: alarm flag, ack latch, rearm timer, warning flag
module vsaa_chan import vsaa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vsaa_ch_ctl_t ctl_i,
  output vsaa_ch_st_t  st_o
);

  logic             alarm_q, alarm_d;
  logic             ack_q, ack_d;
  logic             warn_q, warn_d;
  logic [TMR_W-1:0] tmr_q, tmr_d;
  logic [TMR_W-1:0] tmr_inc;

  always_comb begin
    tmr_inc = tmr_q + 1'b1;
    alarm_d = alarm_q;
    ack_d   = ack_q | ctl_i.ack_set;
    warn_d  = warn_q;
    tmr_d   = tmr_q;
    if (ctl_i.eval) begin
      if (ctl_i.alarm_band) begin
        if (ack_q) begin
          if (tmr_inc >= REARM_CNT) begin
            alarm_d = 1'b1;
            ack_d   = 1'b0;
            tmr_d   = '0;
          end else begin
            tmr_d = tmr_inc;
          end
        end else begin
          alarm_d = 1'b1;
          tmr_d   = '0;
        end
      end else begin
        if (alarm_q) begin
          alarm_d = 1'b0;
          tmr_d   = '0;
        end
        ack_d  = 1'b0;
        warn_d = ctl_i.warn_band;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
      ack_q   <= 1'b0;
      warn_q  <= 1'b0;
      tmr_q   <= '0;
    end else begin
      alarm_q <= alarm_d;
      ack_q   <= ack_d;
      warn_q  <= warn_d;
      tmr_q   <= tmr_d;
    end
  end

  assign st_o.alarm = alarm_q;
  assign st_o.warn  = warn_q;

endmodule

`default_nettype wire

### design/vital_sign_alarm_annunciator.sv
// Each transaction passes the serial remainder unit, its registered done handoff,
//   then the evaluate state and the output load state before result valid.
// Input is taken only in ST_IDLE, so the block takes no new transaction before
//   the last result is loaded; a result still stalled holds off further input.
// Reset (rst_ni, async, active low): all flags, latches and timers clear,
//   eval_interval = 1, no result pending.
`default_nettype none
`include "vital_sign_alarm_annunciator_assert.svh"

module vital_sign_alarm_annunciator import vsaa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IV_W-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TS_W-1:0]   time_stamp_i,
  input  logic [RD_W-1:0]   battery_level_i,
  input  logic [RD_W-1:0]   systolic_i,
  input  logic [RD_W-1:0]   diastolic_i,
  input  logic [RD_W-1:0]   pulse_rate_i,
  input  logic [TEMP_W-1:0] temp_tenths_i,
  input  logic [RESP_W-1:0] resp_rate_i,
  input  logic              ack_systolic_i,
  input  logic              ack_pulse_i,
  input  logic              ack_temp_i,
  input  logic              ack_resp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              evaluated_o,
  output logic              battery_low_o,
  output logic              sys_alarm_o,
  output logic              sys_warning_o,
  output logic              dias_warning_o,
  output logic              pulse_alarm_o,
  output logic              pulse_warning_o,
  output logic              temp_alarm_o,
  output logic              temp_warning_o,
  output logic              resp_alarm_o
);

  vsaa_state_e state_q, state_d;

  logic [IV_W-1:0]   ival_q;
  logic [RD_W-1:0]   batt_q, sys_q, dias_q, pulse_q;
  logic [TEMP_W-1:0] temp_q;
  logic [RESP_W-1:0] resp_q;
  logic              eval_q, eval_d;
  logic              batt_low_q, batt_low_d;
  logic              dias_warn_q, dias_warn_d;
  logic              out_valid_q, out_valid_d;
  logic [9:0]        out_q, out_d;

  logic in_acc, mod_start, mod_done, mod_zero, do_eval, out_load;

  vsaa_ch_ctl_t ctl_sys, ctl_pul, ctl_tmp, ctl_rsp;
  vsaa_ch_st_t  st_sys, st_pul, st_tmp, st_rsp;

  logic [BAND_W-1:0] sys_v, dias_v, pulse_v, temp_v, resp_v;

  assign sys_v   = BAND_W'(sys_q);
  assign dias_v  = BAND_W'(dias_q);
  assign pulse_v = BAND_W'(pulse_q);
  assign temp_v  = temp_q;
  assign resp_v  = BAND_W'(resp_q);

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mod_start  = 1'b0;
    do_eval    = 1'b0;
    out_load   = 1'b0;
    eval_d     = eval_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mod_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          eval_d  = mod_zero || (ival_q == '0);
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        do_eval = eval_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  vsaa_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (time_stamp_i),
    .divisor_i  (ival_q),
    .done_o     (mod_done),
    .zero_o     (mod_zero)
  );

  always_comb begin
    ctl_sys.eval       = do_eval;
    ctl_sys.ack_set    = in_acc && ack_systolic_i;
    ctl_sys.alarm_band = out_of_band_f(sys_v, SYS_A_HI, SYS_A_LO);
    ctl_sys.warn_band  = out_of_band_f(sys_v, SYS_W_HI, SYS_W_LO);
    ctl_pul.eval       = do_eval;
    ctl_pul.ack_set    = in_acc && ack_pulse_i;
    ctl_pul.alarm_band = out_of_band_f(pulse_v, PUL_A_HI, PUL_A_LO);
    ctl_pul.warn_band  = out_of_band_f(pulse_v, PUL_W_HI, PUL_W_LO);
    ctl_tmp.eval       = do_eval;
    ctl_tmp.ack_set    = in_acc && ack_temp_i;
    ctl_tmp.alarm_band = out_of_band_f(temp_v, TMP_A_HI, TMP_A_LO);
    ctl_tmp.warn_band  = out_of_band_f(temp_v, TMP_W_HI, TMP_W_LO);
    ctl_rsp.eval       = do_eval;
    ctl_rsp.ack_set    = in_acc && ack_resp_i;
    ctl_rsp.alarm_band = out_of_band_f(resp_v, RSP_A_HI, RSP_A_LO);
    ctl_rsp.warn_band  = 1'b0;
  end

  vsaa_chan u_ch_sys (.clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl_sys), .st_o(st_sys));
  vsaa_chan u_ch_pul (.clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl_pul), .st_o(st_pul));
  vsaa_chan u_ch_tmp (.clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl_tmp), .st_o(st_tmp));
  vsaa_chan u_ch_rsp (.clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl_rsp), .st_o(st_rsp));

  always_comb begin
    batt_low_d  = batt_low_q;
    dias_warn_d = dias_warn_q;
    if (do_eval) begin
      batt_low_d  = batt_q < BATT_LOW_LIM;
      dias_warn_d = out_of_band_f(dias_v, DIA_W_HI, DIA_W_LO);
    end
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d = {st_rsp.alarm, st_tmp.warn, st_tmp.alarm, st_pul.warn, st_pul.alarm,
               dias_warn_q, st_sys.warn, st_sys.alarm, batt_low_q, eval_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ival_q      <= IV_RESET;
      eval_q      <= 1'b0;
      batt_low_q  <= 1'b0;
      dias_warn_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      eval_q      <= eval_d;
      batt_low_q  <= batt_low_d;
      dias_warn_q <= dias_warn_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ival_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      batt_q  <= battery_level_i;
      sys_q   <= systolic_i;
      dias_q  <= diastolic_i;
      pulse_q <= pulse_rate_i;
      temp_q  <= temp_tenths_i;
      resp_q  <= resp_rate_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign evaluated_o     = out_q[0];
  assign battery_low_o   = out_q[1];
  assign sys_alarm_o     = out_q[2];
  assign sys_warning_o   = out_q[3];
  assign dias_warning_o  = out_q[4];
  assign pulse_alarm_o   = out_q[5];
  assign pulse_warning_o = out_q[6];
  assign temp_alarm_o    = out_q[7];
  assign temp_warning_o  = out_q[8];
  assign resp_alarm_o    = out_q[9];

  `VSAA_ASSERT_NXT(a_acc_starts_div, in_acc, state_q == ST_DIV)
  `VSAA_ASSERT_IMP(a_done_in_div, mod_done, state_q == ST_DIV)
  `VSAA_ASSERT_NXT(a_load_sets_valid, out_load, out_valid_q && state_q == ST_IDLE)
  `VSAA_ASSERT_IMP(a_eval_only_eval_st, do_eval, state_q == ST_EVAL && eval_q)

endmodule

`default_nettype wire
